>>> design/blo_pkg.sv
// Shared types and codes for the bounded ordered list engine.
`timescale 1ns / 1ps

package blo_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 4;
    localparam int KIND_W = 3;
    localparam int POS_W  = 8;

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 4'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 4'd1;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 4'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd5;
    localparam logic [CMD_W-1:0] CMD_SIZE       = 4'd6;
    localparam logic [CMD_W-1:0] CMD_GET        = 4'd7;
    localparam logic [CMD_W-1:0] CMD_PRINT      = 4'd8;

    localparam logic [KIND_W-1:0] KIND_SIZE        = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GET         = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GET_ERR     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PRINT_ELEM  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PRINT_EMPTY = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_GET   = 5'b00010,
        S_PRINT = 5'b00100,
        S_SCAN  = 5'b01000,
        S_SHIFT = 5'b10000
    } t_state;

endpackage

>>> design/blo_unit.sv
// Shared ring address adder and element comparator.
`timescale 1ns / 1ps

module blo_unit #(
    parameter int CAPACITY = 32
) (
    input  logic [$clog2(CAPACITY)-1:0]        i_base,
    input  logic [$clog2(CAPACITY)-1:0]        i_ofs,
    output logic [$clog2(CAPACITY)-1:0]        o_addr,
    input  logic signed [blo_pkg::DATA_W-1:0]  i_lhs,
    input  logic signed [blo_pkg::DATA_W-1:0]  i_rhs,
    output logic                               o_equal
);

    localparam int AW = $clog2(CAPACITY);
    localparam logic [AW:0] CAP_EXT = (AW+1)'(CAPACITY);

    logic [AW:0] sum;
    logic [AW:0] sum_wrap;

    // both operands are below CAPACITY, so one subtract folds the sum back
    assign sum      = {1'b0, i_base} + {1'b0, i_ofs};
    assign sum_wrap = sum - CAP_EXT;
    assign o_addr   = (sum >= CAP_EXT) ? sum_wrap[AW-1:0] : sum[AW-1:0];
    assign o_equal  = (i_lhs == i_rhs);

endmodule

>>> design/bounded_ordered_list_engine.sv
// Top level: deque of signed values in a ring memory, run by a small sequencer.
`timescale 1ns / 1ps

//  channel   signals                                             direction
//  request   start, busy, i_command, i_item_value, i_position    in (busy out)
//  reply     o_valid, o_reply_kind, o_reply_value, o_last_of_run out
//
//  Push, pop and clear finish without leaving idle; size replies in the cycle after the request.
//  Get: one read of the memory read port, then the reply.
//  Print sends one element per cycle off the memory read port.
//  Remove runs a scan, then a one-slot shift per cycle.
//  Reset clears the count; the memory holds garbage until written. Replies cannot be stalled.

module bounded_ordered_list_engine #(
    parameter int CAPACITY = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    input  logic [blo_pkg::CMD_W-1:0]             i_command,
    input  logic signed [blo_pkg::DATA_W-1:0]     i_item_value,
    input  logic [blo_pkg::POS_W-1:0]             i_position,
    output logic                                  busy,
    output logic                                  o_valid,
    output logic [blo_pkg::KIND_W-1:0]            o_reply_kind,
    output logic signed [blo_pkg::DATA_W-1:0]     o_reply_value,
    output logic                                  o_last_of_run
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = blo_pkg::DATA_W;
    localparam int PW = blo_pkg::POS_W + 1;
    localparam logic [AW-1:0] OFS_ONE  = AW'(1);
    localparam logic [AW-1:0] OFS_BACK = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    blo_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_rptr, n_rptr;
    logic [AW-1:0]   r_wptr, n_wptr;
    logic [CW-1:0]   r_left, n_left;
    logic signed [DW-1:0] r_val, n_val;

    logic signed [DW-1:0] mem [CAPACITY];
    logic signed [DW-1:0] r_rdata;
    logic                 rd_en;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic signed [DW-1:0] wr_data;

    logic [AW-1:0] u_base;
    logic [AW-1:0] u_ofs;
    logic [AW-1:0] u_addr;
    logic          u_equal;

    logic                  accept;
    logic                  r_valid, n_valid;
    logic [blo_pkg::KIND_W-1:0] n_kind;
    logic signed [DW-1:0]  n_value;
    logic                  n_last;

    blo_unit #(
        .CAPACITY (CAPACITY)
    ) u_unit (
        .i_base  (u_base),
        .i_ofs   (u_ofs),
        .o_addr  (u_addr),
        .i_lhs   (r_rdata),
        .i_rhs   (r_val),
        .o_equal (u_equal)
    );

    assign busy    = (r_state != blo_pkg::S_IDLE);
    assign accept  = start && !busy;
    assign o_valid = r_valid;

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_count = r_count;
        n_rptr  = r_rptr;
        n_wptr  = r_wptr;
        n_left  = r_left;
        n_val   = r_val;
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        wr_addr = u_addr;
        wr_data = i_item_value;
        u_base  = r_head;
        u_ofs   = '0;
        n_valid = 1'b0;
        n_kind  = blo_pkg::KIND_SIZE;
        n_value = '0;
        n_last  = 1'b1;

        unique case (r_state)
            blo_pkg::S_IDLE: begin
                if (accept) begin
                    n_val = i_item_value;
                    unique case (i_command)
                        blo_pkg::CMD_PUSH_BACK: begin
                            u_ofs = r_count[AW-1:0];
                            if (r_count < CNT_FULL) begin
                                wr_en   = 1'b1;
                                n_count = r_count + CNT_ONE;
                            end
                        end
                        blo_pkg::CMD_PUSH_FRONT: begin
                            u_ofs = OFS_BACK;
                            if (r_count < CNT_FULL) begin
                                wr_en   = 1'b1;
                                n_head  = u_addr;
                                n_count = r_count + CNT_ONE;
                            end
                        end
                        blo_pkg::CMD_POP_BACK: begin
                            if (r_count != '0) n_count = r_count - CNT_ONE;
                        end
                        blo_pkg::CMD_POP_FRONT: begin
                            u_ofs = OFS_ONE;
                            if (r_count != '0) begin
                                n_head  = u_addr;
                                n_count = r_count - CNT_ONE;
                            end
                        end
                        blo_pkg::CMD_REMOVE: begin
                            if (r_count != '0) begin
                                rd_en   = 1'b1;
                                n_rptr  = u_addr;
                                n_left  = r_count - CNT_ONE;
                                n_state = blo_pkg::S_SCAN;
                            end
                        end
                        blo_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        blo_pkg::CMD_SIZE: begin
                            n_valid = 1'b1;
                            n_kind  = blo_pkg::KIND_SIZE;
                            n_value = DW'(r_count);
                        end
                        blo_pkg::CMD_GET: begin
                            u_ofs = i_position[AW-1:0];
                            if (PW'(i_position) < PW'(r_count)) begin
                                rd_en   = 1'b1;
                                n_state = blo_pkg::S_GET;
                            end else begin
                                n_valid = 1'b1;
                                n_kind  = blo_pkg::KIND_GET_ERR;
                            end
                        end
                        blo_pkg::CMD_PRINT: begin
                            if (r_count == '0) begin
                                n_valid = 1'b1;
                                n_kind  = blo_pkg::KIND_PRINT_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                n_rptr  = u_addr;
                                n_left  = r_count - CNT_ONE;
                                n_state = blo_pkg::S_PRINT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            blo_pkg::S_GET: begin
                n_valid = 1'b1;
                n_kind  = blo_pkg::KIND_GET;
                n_value = r_rdata;
                n_state = blo_pkg::S_IDLE;
            end
            blo_pkg::S_PRINT: begin
                u_base  = r_rptr;
                u_ofs   = OFS_ONE;
                n_valid = 1'b1;
                n_kind  = blo_pkg::KIND_PRINT_ELEM;
                n_value = r_rdata;
                n_last  = (r_left == '0);
                if (r_left == '0) begin
                    n_state = blo_pkg::S_IDLE;
                end else begin
                    rd_en  = 1'b1;
                    n_rptr = u_addr;
                    n_left = r_left - CNT_ONE;
                end
            end
            blo_pkg::S_SCAN: begin
                u_base = r_rptr;
                u_ofs  = OFS_ONE;
                if (r_left == '0) begin
                    if (u_equal) n_count = r_count - CNT_ONE;
                    n_state = blo_pkg::S_IDLE;
                end else begin
                    rd_en  = 1'b1;
                    n_rptr = u_addr;
                    n_left = r_left - CNT_ONE;
                    if (u_equal) begin
                        // matched slot becomes the first hole to fill
                        n_wptr  = r_rptr;
                        n_state = blo_pkg::S_SHIFT;
                    end
                end
            end
            blo_pkg::S_SHIFT: begin
                u_base  = r_rptr;
                u_ofs   = OFS_ONE;
                wr_en   = 1'b1;
                wr_addr = r_wptr;
                wr_data = r_rdata;
                n_wptr  = r_rptr;
                if (r_left == '0) begin
                    n_count = r_count - CNT_ONE;
                    n_state = blo_pkg::S_IDLE;
                end else begin
                    rd_en  = 1'b1;
                    n_rptr = u_addr;
                    n_left = r_left - CNT_ONE;
                end
            end
            default: n_state = blo_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= blo_pkg::S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rptr        <= n_rptr;
        r_wptr        <= n_wptr;
        r_left        <= n_left;
        r_val         <= n_val;
        o_reply_kind  <= n_kind;
        o_reply_value <= n_value;
        o_last_of_run <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) r_rdata <= mem[u_addr];
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("element count above capacity");

    a_mid_print: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |-> $past(r_state == blo_pkg::S_PRINT))
        else $error("non-final reply outside a print run");

    a_size_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_command == blo_pkg::CMD_SIZE |=> o_valid && o_last_of_run)
        else $error("size request gave no reply");

    a_remove_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == blo_pkg::S_SCAN || r_state == blo_pkg::S_SHIFT |=> !o_valid)
        else $error("reply during remove");

    a_no_grow_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == blo_pkg::S_SCAN || r_state == blo_pkg::S_SHIFT
        |=> r_count <= $past(r_count))
        else $error("remove grew the list");

endmodule
